@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL of the slot table.
// No dependencies; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property clocked on the rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/ost_pkg.sv @@
// Types and codes for the occupancy slot table.
// No dependencies; used by ost_store and occupancy_slot_table.
`default_nettype none

package ost_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_PUSH   = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_SWAP   = 3'd4,
    REQ_REMOVE = 3'd5,
    REQ_READ   = 3'd6
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_TAKEN    = 3'd2,
    ST_NOT_SET  = 3'd3,
    ST_NOT_INIT = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]         req_type;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          position_b;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          slot_used;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ost_first_free.sv @@
// Lowest-set-bit priority encoder over the free-slot vector.
// No package dependency; used by ost_store.
`default_nettype none

module ost_first_free #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic [TABLE_DEPTH-1:0]         free,
  output logic                                any,
  output logic [$clog2(TABLE_DEPTH)-1:0]      idx
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [TABLE_DEPTH-1:0] lowest;

  // isolate the lowest set bit: x & -x
  assign lowest = free & (~free + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  assign any    = |free;

  // one-hot to binary: each index bit ORs the entries that carry it
  always_comb begin
    idx = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx[b] = idx[b] | lowest[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ost_store.sv @@
// Slot storage, occupancy bits and the request decode that acts on them.
// Depends on ost_pkg, ost_first_free and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ost_store #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          exec,
  input  wire ost_pkg::req_t req,
  output ost_pkg::rsp_t      rsp
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [ost_pkg::VALUE_W-1:0] data [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      used;
  logic [TABLE_DEPTH-1:0]      used_next;
  logic                        initialized;
  logic                        initialized_next;

  logic                        ff_any;
  logic [IDX_W-1:0]            ff_idx;

  logic                        in_a, in_b, used_a, used_b;
  logic [IDX_W-1:0]            ia, ib;
  logic                        wr_a, wr_b;
  logic [IDX_W-1:0]            wr_a_addr;
  logic [ost_pkg::VALUE_W-1:0] wr_a_data, wr_b_data;
  logic                        value_nz;

  ost_first_free #(.TABLE_DEPTH(TABLE_DEPTH)) u_first_free (
    .free (~used),
    .any  (ff_any),
    .idx  (ff_idx)
  );

  assign ia       = IDX_W'(req.position);
  assign ib       = IDX_W'(req.position_b);
  assign in_a     = 32'(req.position) < 32'(TABLE_DEPTH);
  assign in_b     = 32'(req.position_b) < 32'(TABLE_DEPTH);
  assign used_a   = in_a && used[ia];
  assign used_b   = in_b && used[ib];
  assign value_nz = req.value != '0;

  // a slot whose occupancy bit is low reads as zero, so clear needs no sweep
  always_comb begin
    rsp.status       = ost_pkg::ST_OK;
    rsp.read_value   = '0;
    rsp.slot_used    = req.position;
    used_next        = used;
    initialized_next = initialized;
    wr_a             = 1'b0;
    wr_a_addr        = ia;
    wr_a_data        = req.value;
    wr_b             = 1'b0;
    wr_b_data        = data[ia];
    if (req.req_type == ost_pkg::REQ_CLEAR) begin
      used_next        = '0;
      initialized_next = 1'b1;
    end else if (!initialized) begin
      rsp.status = ost_pkg::ST_NOT_INIT;
    end else begin
      case (req.req_type)
        ost_pkg::REQ_PUSH: begin
          if (ff_any) begin
            wr_a              = 1'b1;
            wr_a_addr         = ff_idx;
            used_next[ff_idx] = value_nz;
            rsp.slot_used     = ost_pkg::POS_W'(ff_idx);
          end else begin
            rsp.status = ost_pkg::ST_FULL;
          end
        end
        ost_pkg::REQ_INSERT: begin
          if (!in_a) begin
            rsp.status = ost_pkg::ST_NOT_SET;
          end else if (used_a) begin
            rsp.status = ost_pkg::ST_TAKEN;
          end else begin
            wr_a          = 1'b1;
            used_next[ia] = value_nz;
          end
        end
        ost_pkg::REQ_UPDATE: begin
          if (!used_a) begin
            rsp.status = ost_pkg::ST_NOT_SET;
          end else begin
            wr_a          = 1'b1;
            used_next[ia] = value_nz;
          end
        end
        ost_pkg::REQ_SWAP: begin
          // both slots in use, so occupancy bits stay as they are
          if (!used_a || !used_b) begin
            rsp.status = ost_pkg::ST_NOT_SET;
          end else begin
            wr_a      = 1'b1;
            wr_a_data = data[ib];
            wr_b      = 1'b1;
          end
        end
        ost_pkg::REQ_REMOVE: begin
          if (!used_a) begin
            rsp.status = ost_pkg::ST_NOT_SET;
          end else begin
            used_next[ia] = 1'b0;
          end
        end
        ost_pkg::REQ_READ: begin
          if (!in_a) begin
            rsp.status = ost_pkg::ST_NOT_SET;
          end else if (used_a) begin
            rsp.read_value = data[ia];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      initialized <= 1'b0;
    end else if (exec) begin
      used        <= used_next;
      initialized <= initialized_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && wr_a) begin
      data[wr_a_addr] <= wr_a_data;
    end
    if (exec && wr_b) begin
      data[ib] <= wr_b_data;
    end
  end

  `ASSERT_CLK(a_clear_empties, clk, rst,
              (exec && req.req_type == ost_pkg::REQ_CLEAR) |=> (initialized && used == '0),
              "clear did not empty the table")
  `ASSERT_CLK(a_uninit_frozen, clk, rst,
              (exec && !initialized && req.req_type != ost_pkg::REQ_CLEAR) |=> $stable(used),
              "table changed before first clear")
  `ASSERT_CLK(a_full_means_all_used, clk, rst,
              (exec && rsp.status == ost_pkg::ST_FULL) |-> (used == '1),
              "full reported with a free slot")

endmodule

`default_nettype wire

@@ hw/rtl/occupancy_slot_table.sv @@
// Top level of the occupancy slot table: request register, store, result register.
// Depends on ost_pkg, ost_store and assert_macros.svh.
//
//   channel | direction | word          | handshake
//   --------+-----------+---------------+--------------------------
//   req     | in        | ost_pkg::req_t | req_valid / req_stall
//   rsp     | out       | ost_pkg::rsp_t | rsp_valid / rsp_stall
//
// One request per cycle sustained while rsp_stall is low. A request is
// accepted into the request register, executes against the flop store and
// the first-free encoder, and lands in the result register, where rsp_valid
// marks its result word. Reset (rst, synchronous) empties both registers
// and leaves the table uninitialized; no clearing pass is needed. A stalled
// result holds the pipe: req_stall rises only when a request waits and the
// result is stuck.
`default_nettype none
`include "assert_macros.svh"

module occupancy_slot_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ost_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ost_pkg::rsp_t      rsp
);

  ost_pkg::req_t held;
  logic          held_valid;
  ost_pkg::rsp_t result;
  logic          advance;
  logic          req_take;

  // the held request executes whenever the result register can take its answer
  assign advance   = held_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = held_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  ost_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk  (clk),
    .rst  (rst),
    .exec (advance),
    .req  (held),
    .rsp  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_take) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (req_take) begin
      held <= req;
    end
    if (advance) begin
      rsp <= result;
    end
  end

  `ASSERT_CLK(a_stall_only_when_busy, clk, rst,
              req_stall |-> (held_valid && rsp_valid),
              "request stalled with room in the pipe")
  `ASSERT_CLK(a_advance_fills_result, clk, rst,
              advance |=> rsp_valid,
              "executed request produced no result")
  `ASSERT_CLK(a_no_drop_on_stall, clk, rst,
              (held_valid && !advance) |=> (held_valid && $stable(held)),
              "waiting request lost")

endmodule

`default_nettype wire
